/* rtl/imm_pkg.sv */
// Shared types, constants and helpers for the integer matrix multiplier.
// Used by imm_ctrl, imm_mac and the top level; depends on nothing else.
package imm_pkg;

  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int SIZE_W  = 4;
  localparam int ELEM_W  = 32;
  localparam int ACC_W   = 64;
  localparam int CFG_W   = 2;

  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Transaction codes on the mode field
  typedef enum logic [1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_COMPUTE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  // Register indexes on the configuration port
  typedef enum logic [CFG_W-1:0] {
    REG_LEFT_ROWS  = 2'd0,
    REG_INNER_SIZE = 2'd1,
    REG_RIGHT_COLS = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // One multiply-accumulate step travelling from sequencer to datapath
  typedef struct packed {
    logic valid;
    logic first;   // opens a new product entry
    logic last;    // closes the entry
    logic zero;    // empty inner dimension: contribute nothing
    logic final_e; // last entry of the product matrix
    idx_t row;
    idx_t col;
  } beat_t;

  // Clamp a size register to the array bound
  function automatic size_t sat_size(input size_t v);
    if (v > size_t'(MAX_DIM)) begin
      return size_t'(MAX_DIM);
    end
    return v;
  endfunction

endpackage

/* rtl/imm_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package needed.
module imm_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/imm_ctrl.sv */
// Sequencer: walks row, column and inner index of the product and issues
// store read addresses with one step per cycle while running. Depends on imm_pkg.
module imm_ctrl import imm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  go,
  input  size_t rows,
  input  size_t inner,
  input  size_t cols,
  output logic  busy,
  output addr_t a_raddr,
  output addr_t b_raddr,
  output beat_t beat
);

  state_t state, state_next;
  idx_t   i, i_next, j, j_next, t, t_next;
  logic   t_last, j_last, i_last, k_zero;

  // Hold state and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      t     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      t     <= t_next;
    end
  end

  assign k_zero = (inner == '0);
  assign t_last = k_zero || ((size_t'(t) + size_t'(1)) == inner);
  assign j_last = (size_t'(j) + size_t'(1)) == cols;
  assign i_last = (size_t'(i) + size_t'(1)) == rows;

  assign a_raddr = {i, t};
  assign b_raddr = {t, j};
  assign busy    = (state == ST_RUN);

  // Next state, counter advance and step issue
  always_comb begin
    state_next   = state;
    i_next       = i;
    j_next       = j;
    t_next       = t;
    beat         = '0;
    beat.first   = (t == '0);
    beat.last    = t_last;
    beat.zero    = k_zero;
    beat.final_e = i_last && j_last && t_last;
    beat.row     = i;
    beat.col     = j;
    unique case (state)
      ST_IDLE: begin
        i_next = '0;
        j_next = '0;
        t_next = '0;
        if (go && rows != '0 && cols != '0) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        beat.valid = 1'b1;
        if (t_last) begin
          t_next = '0;
          if (j_last) begin
            j_next = '0;
            if (i_last) begin
              state_next = ST_IDLE;
            end else begin
              i_next = i + idx_t'(1);
            end
          end else begin
            j_next = j + idx_t'(1);
          end
        end else begin
          t_next = t + idx_t'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/imm_mac.sv */
// Multiply-accumulate datapath: registered product, 64-bit wrapping
// accumulator and result register. Depends on imm_pkg.
module imm_mac import imm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  beat_t                   beat,
  input  logic [ELEM_W-1:0]       a_data,
  input  logic [ELEM_W-1:0]       b_data,
  output logic                    out_valid,
  output idx_t                    out_row,
  output idx_t                    out_col,
  output logic signed [ACC_W-1:0] product_entry,
  output logic                    last
);

  beat_t                   s1, s2;
  logic signed [ELEM_W-1:0] a_s, b_s;
  logic signed [ACC_W-1:0]  prod, acc, acc_next;

  assign a_s = $signed(a_data);
  assign b_s = $signed(b_data);

  // Align step flags with store read data, then with the product
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
    end else begin
      s1.valid <= beat.valid;
      s2.valid <= s1.valid;
    end
    s1.first   <= beat.first;
    s1.last    <= beat.last;
    s1.zero    <= beat.zero;
    s1.final_e <= beat.final_e;
    s1.row     <= beat.row;
    s1.col     <= beat.col;
    s2.first   <= s1.first;
    s2.last    <= s1.last;
    s2.zero    <= s1.zero;
    s2.final_e <= s1.final_e;
    s2.row     <= s1.row;
    s2.col     <= s1.col;
  end

  // Register the signed product; an empty inner dimension contributes zero
  always_ff @(posedge clk) begin
    if (s1.zero) begin
      prod <= '0;
    end else begin
      prod <= a_s * b_s;
    end
  end

  assign acc_next = (s2.first ? ACC_W'(0) : acc) + prod;

  // Accumulate
  always_ff @(posedge clk) begin
    if (s2.valid) begin
      acc <= acc_next;
    end
  end

  // Present a finished entry for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2.valid && s2.last;
    end
    if (s2.valid && s2.last) begin
      out_row       <= s2.row;
      out_col       <= s2.col;
      product_entry <= acc_next;
      last          <= s2.final_e;
    end
  end

endmodule

/* rtl/integer_matrix_multiply.sv */
// Top level of the signed integer matrix multiplier.
// Depends on imm_pkg, imm_ram, imm_ctrl and imm_mac.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   Mode 0 writes element into A at (row_index, col_index), mode 1 into B;
//   writes outside the current sizes are dropped. Loads leave busy low, so
//   loads may follow every cycle. Mode 2 computes C = A * B. Busy is high
//   while the product is walked, one multiply-accumulate per cycle, set by
//   the single read port of each element store. Entries come out in
//   row-major order through the store read, product and result registers,
//   each on out_valid for one cycle. The last entry carries last. Zero rows
//   or cols yield no output. Size registers are written through
//   cfg_write/cfg_index/cfg_data; the user must do so only while idle,
//   which the block does not enforce. Values above 8 act as 8. The receiver
//   cannot stall: results are strobed and must be taken as they appear.
//   Reset (rst, synchronous) sets all sizes to 8 and returns to idle; the
//   stores are not cleared and must be written before they are used.
module integer_matrix_multiply import imm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               mode,
  input  logic [IDX_W-1:0]         row_index,
  input  logic [IDX_W-1:0]         col_index,
  input  logic signed [ELEM_W-1:0] element,
  input  logic                     cfg_write,
  input  logic [CFG_W-1:0]         cfg_index,
  input  logic [SIZE_W-1:0]        cfg_data,
  output logic                     out_valid,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  output logic signed [ACC_W-1:0]  product_entry,
  output logic                     last
);

  size_t             left_rows, inner_size, right_cols;
  size_t             m, k, n;
  logic              accept, we_a, we_b, go;
  addr_t             waddr, a_raddr, b_raddr;
  logic [ELEM_W-1:0] a_data, b_data;
  beat_t             beat;

  // Size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      left_rows  <= size_t'(MAX_DIM);
      inner_size <= size_t'(MAX_DIM);
      right_cols <= size_t'(MAX_DIM);
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LEFT_ROWS:  left_rows  <= cfg_data;
        REG_INNER_SIZE: inner_size <= cfg_data;
        REG_RIGHT_COLS: right_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  assign m = sat_size(left_rows);
  assign k = sat_size(inner_size);
  assign n = sat_size(right_cols);

  // Decode the incoming transaction
  assign accept = start && !busy;
  assign waddr  = {row_index, col_index};
  assign we_a   = accept && (mode_t'(mode) == MODE_LOAD_A)
                  && (size_t'(row_index) < m) && (size_t'(col_index) < k);
  assign we_b   = accept && (mode_t'(mode) == MODE_LOAD_B)
                  && (size_t'(row_index) < k) && (size_t'(col_index) < n);
  assign go     = accept && (mode_t'(mode) == MODE_COMPUTE);

  imm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_left_store (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (element),
    .raddr (a_raddr),
    .rdata (a_data)
  );

  imm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_right_store (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (element),
    .raddr (b_raddr),
    .rdata (b_data)
  );

  imm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .rows    (m),
    .inner   (k),
    .cols    (n),
    .busy    (busy),
    .a_raddr (a_raddr),
    .b_raddr (b_raddr),
    .beat    (beat)
  );

  imm_mac u_mac (
    .clk           (clk),
    .rst           (rst),
    .beat          (beat),
    .a_data        (a_data),
    .b_data        (b_data),
    .out_valid     (out_valid),
    .out_row       (out_row),
    .out_col       (out_col),
    .product_entry (product_entry),
    .last          (last)
  );

endmodule
